// ----- src/bsse_pkg.sv -----
// ----------------------------------------------------------------------------
// bsse_pkg
// shared constants and action codes for the bitmap set scan engine
// ----------------------------------------------------------------------------
package bsse_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int NUM_WORDS_DEF = 64;

  localparam int ACT_W  = 4;
  localparam int IDX_W  = 12;
  localparam int WIDX_W = 6;
  localparam int OPND_W = 64;
  localparam int POS_W  = 12;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 4'd0,
    ACT_WRITE  = 4'd1,
    ACT_FLIP   = 4'd2,
    ACT_TEST   = 4'd3,
    ACT_FIND   = 4'd4,
    ACT_AND    = 4'd5,
    ACT_OR     = 4'd6,
    ACT_XOR    = 4'd7,
    ACT_OR_RPT = 4'd8
  } action_t;

endpackage

// ----- src/bsse_if.sv -----
// ----------------------------------------------------------------------------
// bsse_if
// valid/ready channels for operation items and result items
// ----------------------------------------------------------------------------
interface bsse_in_if import bsse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [IDX_W-1:0]  bit_index;
  logic              bit_value;
  logic [WIDX_W-1:0] word_index;
  logic [OPND_W-1:0] word_value;

  modport source (output valid, action, bit_index, bit_value, word_index, word_value,
                  input ready);
  modport sink (input valid, action, bit_index, bit_value, word_index, word_value,
                output ready);
endinterface

interface bsse_out_if import bsse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             bit_read;
  logic             found;
  logic [POS_W-1:0] position;
  logic             any_set;
  logic             last;

  modport source (output valid, bit_read, found, position, any_set, last,
                  input ready);
  modport sink (input valid, bit_read, found, position, any_set, last,
                output ready);
endinterface

// ----- src/bsse_lsb.sv -----
// ----------------------------------------------------------------------------
// bsse_lsb
// lowest set bit finder shared by the search and the new-bit report
// ----------------------------------------------------------------------------
module bsse_lsb import bsse_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int BW = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word,
  output logic                 hit,
  output logic [BW-1:0]        idx
);

  always_comb begin
    hit = |word;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        idx = BW'(i);
      end
    end
  end

endmodule

// ----- src/bitmap_set_scan_engine_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_set_scan_engine_top
// every item first splits the bit index into word and bit offset by a
// reciprocal multiply; then bit and word ops read and write back one word,
// clear all zeroes every word, a search reads one word per cycle through the
// memory read port, each ending in the result register, and a new-bit report
// gives one result per cycle while the output is not stalled; one item is in
// work at a time; after reset a clearing pass zeroes the bitmap memory,
// with no item accepted until it ends
// ----------------------------------------------------------------------------
module bitmap_set_scan_engine_top import bsse_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bsse_in_if.sink   in_ch,
  bsse_out_if.source out_ch
);

  localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SW    = AW + 1;
  localparam int BW    = $clog2(WORD_BITS);
  localparam int CW    = $clog2(NUM_WORDS + 1);
  localparam int QW    = IDX_W + 1;
  localparam int DIV_S = IDX_W + BW;
  localparam int DIV_M = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
  localparam int MW    = IDX_W + 1;
  localparam int PW    = IDX_W + MW;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CLR  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_DISP = 9'b000001000,
    S_RD   = 9'b000010000,
    S_MOD  = 9'b000100000,
    S_SRCH = 9'b001000000,
    S_RPT  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  action_t              act_r, act_nxt;
  logic [IDX_W-1:0]     bidx_r, bidx_nxt;
  logic                 bval_r, bval_nxt;
  logic [WIDX_W-1:0]    widx_r, widx_nxt;
  logic [WORD_BITS-1:0] wval_r, wval_nxt;
  logic [IDX_W-1:0]     quo_r, quo_nxt;
  logic [BW-1:0]        rem_r, rem_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [SW-1:0]        scan_r, scan_nxt;
  logic [AW-1:0]        eval_r, eval_nxt;
  logic                 qv_r, qv_nxt;
  logic                 first_r, first_nxt;
  logic [POS_W-1:0]     base_r, base_nxt;
  logic [WORD_BITS-1:0] upd_r, upd_nxt;
  logic                 res_rd_r, res_rd_nxt;
  logic                 res_fnd_r, res_fnd_nxt;
  logic [POS_W-1:0]     res_pos_r, res_pos_nxt;
  logic [CW-1:0]        nz_r, nz_nxt;
  logic                 init_r, init_nxt;

  logic                 ov_r, ov_nxt;
  logic                 o_rd_r, o_rd_nxt;
  logic                 o_fnd_r, o_fnd_nxt;
  logic [POS_W-1:0]     o_pos_r, o_pos_nxt;
  logic                 o_any_r, o_any_nxt;
  logic                 o_last_r, o_last_nxt;

  logic [WORD_BITS-1:0] bitmap_r [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [PW-1:0]        div_prod;
  logic [IDX_W-1:0]     word_base;
  logic [WORD_BITS-1:0] sel;
  logic [WORD_BITS-1:0] upd_new;
  logic [WORD_BITS-1:0] upd_rest;
  logic                 out_free;
  logic [WORD_BITS-1:0] lsb_word;
  logic                 lsb_hit;
  logic [BW-1:0]        lsb_idx;

  bsse_lsb #(.WORD_BITS(WORD_BITS)) u_lsb (
    .word (lsb_word),
    .hit  (lsb_hit),
    .idx  (lsb_idx)
  );

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = ov_r;
  assign out_ch.bit_read = o_rd_r;
  assign out_ch.found    = o_fnd_r;
  assign out_ch.position = o_pos_r;
  assign out_ch.any_set  = o_any_r;
  assign out_ch.last     = o_last_r;

  assign out_free  = !ov_r || out_ch.ready;
  assign div_prod  = PW'(bidx_r) * PW'(DIV_M);
  assign word_base = IDX_W'(quo_r * IDX_W'(WORD_BITS));
  assign sel       = WORD_BITS'(1) << rem_r;
  assign upd_new   = wval_r & ~rdata_r;
  assign upd_rest  = upd_r & (upd_r - WORD_BITS'(1));

  always_comb begin
    if (state_r == S_RPT) begin
      lsb_word = upd_r;
    end else if (first_r) begin
      lsb_word = rdata_r & ({WORD_BITS{1'b1}} << rem_r);
    end else begin
      lsb_word = rdata_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    bidx_nxt    = bidx_r;
    bval_nxt    = bval_r;
    widx_nxt    = widx_r;
    wval_nxt    = wval_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    addr_nxt    = addr_r;
    scan_nxt    = scan_r;
    eval_nxt    = eval_r;
    qv_nxt      = 1'b0;
    first_nxt   = first_r;
    base_nxt    = base_r;
    upd_nxt     = upd_r;
    res_rd_nxt  = res_rd_r;
    res_fnd_nxt = res_fnd_r;
    res_pos_nxt = res_pos_r;
    nz_nxt      = nz_r;
    init_nxt    = init_r;
    ov_nxt      = ov_r && !out_ch.ready;
    o_rd_nxt    = o_rd_r;
    o_fnd_nxt   = o_fnd_r;
    o_pos_nxt   = o_pos_r;
    o_any_nxt   = o_any_r;
    o_last_nxt  = o_last_r;
    rd_addr     = addr_r;
    mem_we      = 1'b0;
    mem_wdata   = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt     = action_t'(in_ch.action);
          bidx_nxt    = in_ch.bit_index;
          bval_nxt    = in_ch.bit_value;
          widx_nxt    = in_ch.word_index;
          wval_nxt    = in_ch.word_value[WORD_BITS-1:0];
          quo_nxt     = '0;
          rem_nxt     = '0;
          res_rd_nxt  = 1'b0;
          res_fnd_nxt = 1'b0;
          res_pos_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (addr_r == AW'(NUM_WORDS - 1)) begin
          nz_nxt = '0;
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_DIV: begin
        quo_nxt   = IDX_W'(div_prod >> DIV_S);
        state_nxt = S_DISP;
      end
      S_DISP: begin
        rem_nxt = BW'(bidx_r - word_base);
        case (act_r)
          ACT_CLEAR: begin
            addr_nxt  = '0;
            state_nxt = S_CLR;
          end
          ACT_WRITE, ACT_FLIP, ACT_TEST: begin
            if ({1'b0, quo_r} < QW'(NUM_WORDS)) begin
              addr_nxt  = AW'(quo_r);
              state_nxt = S_RD;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          ACT_FIND: begin
            if ({1'b0, quo_r} < QW'(NUM_WORDS)) begin
              scan_nxt  = SW'(quo_r);
              eval_nxt  = AW'(quo_r);
              first_nxt = 1'b1;
              base_nxt  = POS_W'(word_base);
              state_nxt = S_SRCH;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          ACT_AND, ACT_OR, ACT_XOR, ACT_OR_RPT: begin
            if (QW'(widx_r) < QW'(NUM_WORDS)) begin
              addr_nxt  = AW'(widx_r);
              base_nxt  = POS_W'(POS_W'(widx_r) * POS_W'(WORD_BITS));
              state_nxt = S_RD;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        mem_we    = 1'b1;
        state_nxt = S_EMIT;
        case (act_r)
          ACT_WRITE: mem_wdata = bval_r ? (rdata_r | sel) : (rdata_r & ~sel);
          ACT_FLIP:  mem_wdata = rdata_r ^ sel;
          ACT_TEST:  res_rd_nxt = rdata_r[rem_r];
          ACT_AND:   mem_wdata = rdata_r & wval_r;
          ACT_OR:    mem_wdata = rdata_r | wval_r;
          ACT_XOR:   mem_wdata = rdata_r ^ wval_r;
          ACT_OR_RPT: begin
            mem_wdata = rdata_r | upd_new;
            upd_nxt   = upd_new;
            if (upd_new != '0) begin
              state_nxt = S_RPT;
            end
          end
          default: mem_wdata = rdata_r;
        endcase
        if ((mem_wdata != '0) && (rdata_r == '0)) begin
          nz_nxt = nz_r + CW'(1);
        end else if ((mem_wdata == '0) && (rdata_r != '0)) begin
          nz_nxt = nz_r - CW'(1);
        end
      end
      S_SRCH: begin
        if (scan_r < SW'(NUM_WORDS)) begin
          rd_addr  = AW'(scan_r);
          scan_nxt = scan_r + SW'(1);
          qv_nxt   = 1'b1;
        end
        if (qv_r) begin
          first_nxt = 1'b0;
          if (lsb_hit) begin
            res_fnd_nxt = 1'b1;
            res_pos_nxt = base_r + POS_W'(lsb_idx);
            state_nxt   = S_EMIT;
          end else if (eval_r == AW'(NUM_WORDS - 1)) begin
            state_nxt = S_EMIT;
          end else begin
            eval_nxt = eval_r + AW'(1);
            base_nxt = base_r + POS_W'(WORD_BITS);
          end
        end
      end
      S_RPT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_rd_nxt   = 1'b0;
          o_fnd_nxt  = 1'b1;
          o_pos_nxt  = base_r + POS_W'(lsb_idx);
          o_any_nxt  = (nz_r != '0);
          o_last_nxt = (upd_rest == '0);
          upd_nxt    = upd_rest;
          if (upd_rest == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_rd_nxt   = res_rd_r;
          o_fnd_nxt  = res_fnd_r;
          o_pos_nxt  = res_pos_r;
          o_any_nxt  = (nz_r != '0);
          o_last_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      addr_r  <= '0;
      init_r  <= 1'b1;
      nz_r    <= '0;
      qv_r    <= 1'b0;
      first_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      init_r  <= init_nxt;
      nz_r    <= nz_nxt;
      qv_r    <= qv_nxt;
      first_r <= first_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    bidx_r    <= bidx_nxt;
    bval_r    <= bval_nxt;
    widx_r    <= widx_nxt;
    wval_r    <= wval_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    scan_r    <= scan_nxt;
    eval_r    <= eval_nxt;
    base_r    <= base_nxt;
    upd_r     <= upd_nxt;
    res_rd_r  <= res_rd_nxt;
    res_fnd_r <= res_fnd_nxt;
    res_pos_r <= res_pos_nxt;
    o_rd_r    <= o_rd_nxt;
    o_fnd_r   <= o_fnd_nxt;
    o_pos_r   <= o_pos_nxt;
    o_any_r   <= o_any_nxt;
    o_last_r  <= o_last_nxt;
  end

  // bitmap memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_r[addr_r] <= mem_wdata;
    end
    rdata_r <= bitmap_r[rd_addr];
  end

endmodule

// ----- src/bsse_chk.sv -----
// ----------------------------------------------------------------------------
// bsse_chk
// port-level checks for the bitmap set scan engine, bound to the top level
// ----------------------------------------------------------------------------
module bsse_chk import bsse_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_bit_read,
  input logic             out_found,
  input logic [POS_W-1:0] out_position
);

  // one item in work at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before its transfer");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_position == '0))
    else $error("position set on a result without a hit");

  a_read_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_bit_read && out_found))
    else $error("bit read and found both set");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bitmap_set_scan_engine_top bsse_chk u_bsse_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_bit_read (out_ch.bit_read),
  .out_found    (out_ch.found),
  .out_position (out_ch.position)
);

// ----- sim/tb_bitmap_set_scan_engine_top.sv -----
// ----------------------------------------------------------------------------
// tb_bitmap_set_scan_engine_top
// checks the bitmap set scan engine against a shadow bitmap in the testbench:
// directed bit, word, search, new-bit report, undefined and clear operations,
// then random mixes with or without random gaps and stalls on both channels;
// every result transfer is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_set_scan_engine_top;
  import bsse_pkg::*;

  localparam int WORD_BITS  = WORD_BITS_DEF;
  localparam int NUM_WORDS  = NUM_WORDS_DEF;
  localparam int TOTAL_BITS = WORD_BITS * NUM_WORDS;
  localparam logic [OPND_W-1:0] WORD_MASK = {OPND_W{1'b1}} >> (OPND_W - WORD_BITS);
  localparam logic [OPND_W-1:0] ALL_ONES  = {OPND_W{1'b1}};
  localparam logic [ACT_W-1:0] ACT_UNDEF_FIRST = 4'd9;
  localparam logic [ACT_W-1:0] ACT_UNDEF_LAST  = 4'd15;
  localparam int MAX_GAP       = 6;
  localparam int SETTLE_CYCLES = NUM_WORDS + 32;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  bit_index;
    logic              bit_value;
    logic [WIDX_W-1:0] word_index;
    logic [OPND_W-1:0] word_value;
  } op_item_t;

  typedef struct packed {
    logic             bit_read;
    logic             found;
    logic [POS_W-1:0] position;
    logic             any_set;
    logic             last;
  } scan_result_t;

  logic clk;
  logic rst_n;

  bsse_in_if  in_ch ();
  bsse_out_if out_ch ();

  bitmap_set_scan_engine_top #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [OPND_W-1:0] shadow_map [NUM_WORDS];
  scan_result_t      expected_results [$];
  int                mismatch_count;
  bit                no_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic map_any_set();
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_WORDS; i++)
      if ((shadow_map[i] & WORD_MASK) != '0) hit = 1'b1;
    return hit;
  endfunction

  function automatic void predict_op(op_item_t op);
    bit                bit_ok;
    bit                word_ok;
    int unsigned       wi;
    int unsigned       scan;
    logic [OPND_W-1:0] sel;
    logic [OPND_W-1:0] w;
    logic [OPND_W-1:0] fresh;
    logic              rd;
    logic              fnd;
    logic [POS_W-1:0]  pos;
    int                low;
    scan_result_t      r;
    bit_ok  = op.bit_index < TOTAL_BITS;
    word_ok = op.word_index < NUM_WORDS;
    wi      = bit_ok ? op.bit_index / WORD_BITS : 0;
    sel     = bit_ok ? (64'd1 << (op.bit_index % WORD_BITS)) : '0;
    rd      = 1'b0;
    fnd     = 1'b0;
    pos     = '0;
    case (op.action)
      ACT_CLEAR: begin
        for (int i = 0; i < NUM_WORDS; i++) shadow_map[i] = '0;
      end
      ACT_WRITE: begin
        if (bit_ok) begin
          if (op.bit_value) shadow_map[wi] = shadow_map[wi] | sel;
          else shadow_map[wi] = shadow_map[wi] & ~sel;
        end
      end
      ACT_FLIP: begin
        if (bit_ok) shadow_map[wi] = shadow_map[wi] ^ sel;
      end
      ACT_TEST: begin
        if (bit_ok) rd = (shadow_map[wi] & sel) != '0;
      end
      ACT_FIND: begin
        if (bit_ok) begin
          scan = wi;
          w = shadow_map[wi] & WORD_MASK & ~(sel - 64'd1);
          while (!fnd && scan < NUM_WORDS) begin
            if (w != '0) begin
              low = 0;
              for (int j = OPND_W - 1; j >= 0; j--) if (w[j]) low = j;
              fnd = 1'b1;
              pos = POS_W'(scan * WORD_BITS + low);
            end else begin
              scan++;
              if (scan < NUM_WORDS) w = shadow_map[scan] & WORD_MASK;
            end
          end
        end
      end
      ACT_AND: begin
        if (word_ok) shadow_map[op.word_index] &= op.word_value & WORD_MASK;
      end
      ACT_OR: begin
        if (word_ok) shadow_map[op.word_index] |= op.word_value & WORD_MASK;
      end
      ACT_XOR: begin
        if (word_ok) shadow_map[op.word_index] ^= op.word_value & WORD_MASK;
      end
      ACT_OR_RPT: begin
        fresh = '0;
        if (word_ok) begin
          fresh = op.word_value & WORD_MASK & ~shadow_map[op.word_index];
          shadow_map[op.word_index] |= fresh;
        end
        if (fresh != '0) begin
          for (int j = 0; j < WORD_BITS; j++) begin
            if (fresh[j]) begin
              r.bit_read = 1'b0;
              r.found    = 1'b1;
              r.position = POS_W'(op.word_index * WORD_BITS + j);
              r.any_set  = map_any_set();
              r.last     = (fresh >> (j + 1)) == '0;
              expected_results = {expected_results, r};
            end
          end
          return;
        end
      end
      default: begin
      end
    endcase
    r.bit_read = rd;
    r.found    = fnd;
    r.position = fnd ? pos : '0;
    r.any_set  = map_any_set();
    r.last     = 1'b1;
    expected_results = {expected_results, r};
  endfunction

  function automatic void check_result();
    scan_result_t exp_r;
    if (expected_results.size() == 0) begin
      $error("result transfer with no prediction: position %0d", out_ch.position);
      mismatch_count++;
      return;
    end
    exp_r = expected_results.pop_front();
    if (out_ch.bit_read !== exp_r.bit_read) begin
      $error("bit_read: expected %0d, actual %0d", exp_r.bit_read, out_ch.bit_read);
      mismatch_count++;
    end
    if (out_ch.found !== exp_r.found) begin
      $error("found: expected %0d, actual %0d", exp_r.found, out_ch.found);
      mismatch_count++;
    end
    if (out_ch.position !== exp_r.position) begin
      $error("position: expected %0d, actual %0d", exp_r.position, out_ch.position);
      mismatch_count++;
    end
    if (out_ch.any_set !== exp_r.any_set) begin
      $error("any_set: expected %0d, actual %0d", exp_r.any_set, out_ch.any_set);
      mismatch_count++;
    end
    if (out_ch.last !== exp_r.last) begin
      $error("last: expected %0d, actual %0d", exp_r.last, out_ch.last);
      mismatch_count++;
    end
  endfunction

  // result side: random stall, then wait for one transfer and check it
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_ch.valid === 1'b1));
      check_result();
    end
  end

  function automatic op_item_t make_op(logic [ACT_W-1:0] action, logic [IDX_W-1:0] bidx,
                                       logic bval, logic [WIDX_W-1:0] widx,
                                       logic [OPND_W-1:0] wval);
    op_item_t op;
    op.action     = action;
    op.bit_index  = bidx;
    op.bit_value  = bval;
    op.word_index = widx;
    op.word_value = wval;
    return op;
  endfunction

  function automatic op_item_t random_op(int hot_words);
    op_item_t op;
    int       pick;
    op.bit_value  = 1'($urandom_range(0, 1));
    op.word_value = {$urandom, $urandom};
    if ($urandom_range(0, 1)) begin
      op.bit_index  = IDX_W'($urandom_range(0, hot_words * WORD_BITS - 1));
      op.word_index = WIDX_W'($urandom_range(0, hot_words - 1));
    end else begin
      op.bit_index  = IDX_W'($urandom_range(0, TOTAL_BITS - 1));
      op.word_index = WIDX_W'($urandom_range(0, NUM_WORDS - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) op.action = ACT_CLEAR;
    else if (pick < 16) op.action = ACT_WRITE;
    else if (pick < 24) op.action = ACT_FLIP;
    else if (pick < 36) op.action = ACT_TEST;
    else if (pick < 56) op.action = ACT_FIND;
    else if (pick < 62) begin
      op.action = ACT_AND;
      op.word_value = op.word_value | {$urandom, $urandom};
    end else if (pick < 68) op.action = ACT_OR;
    else if (pick < 74) op.action = ACT_XOR;
    else if (pick < 94) begin
      op.action = ACT_OR_RPT;
      if ($urandom_range(0, 1))
        op.word_value = op.word_value & {$urandom, $urandom} & {$urandom, $urandom};
    end else op.action = ACT_W'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
    return op;
  endfunction

  task automatic send_op(input op_item_t op);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.action     <= op.action;
    in_ch.bit_index  <= op.bit_index;
    in_ch.bit_value  <= op.bit_value;
    in_ch.word_index <= op.word_index;
    in_ch.word_value <= op.word_value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_op(op);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_single_bits();
    send_op(make_op(ACT_TEST, 12'd0, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_FIND, 12'd0, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_WRITE, 12'd0, 1'b1, 6'd63, ALL_ONES));
    send_op(make_op(ACT_WRITE, 12'd4095, 1'b1, 6'd0, '0));
    send_op(make_op(ACT_TEST, 12'd4095, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_FIND, 12'd1, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_FLIP, 12'd4095, 1'b1, 6'd0, '0));
    send_op(make_op(ACT_FLIP, 12'd64, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_TEST, 12'd64, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_WRITE, 12'd0, 1'b0, 6'd0, ALL_ONES));
    send_op(make_op(ACT_FIND, 12'd0, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_FIND, 12'd65, 1'b0, 6'd0, '0));
    wait_drained();
  endtask

  task automatic test_word_ops();
    send_op(make_op(ACT_OR, 12'd0, 1'b0, 6'd5, ALL_ONES));
    send_op(make_op(ACT_AND, 12'd0, 1'b0, 6'd5, {32{2'b01}}));
    send_op(make_op(ACT_XOR, 12'd0, 1'b0, 6'd63, ALL_ONES));
    send_op(make_op(ACT_OR, 12'd0, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_AND, 12'd0, 1'b0, 6'd63, '0));
    wait_drained();
  endtask

  task automatic test_new_bit_report();
    send_op(make_op(ACT_OR_RPT, 12'd0, 1'b0, 6'd63, ALL_ONES));
    send_op(make_op(ACT_OR_RPT, 12'd0, 1'b0, 6'd63, ALL_ONES));
    send_op(make_op(ACT_OR_RPT, 12'd0, 1'b0, 6'd5, ALL_ONES));
    send_op(make_op(ACT_OR_RPT, 12'd0, 1'b0, 6'd1, {1'b1, 62'd0, 1'b1}));
    wait_drained();
  endtask

  task automatic test_undefined_and_clear();
    send_op(make_op(ACT_UNDEF_FIRST, 12'd4095, 1'b1, 6'd63, ALL_ONES));
    send_op(make_op(ACT_UNDEF_LAST, 12'd0, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_CLEAR, 12'd4095, 1'b1, 6'd63, ALL_ONES));
    send_op(make_op(ACT_FIND, 12'd0, 1'b0, 6'd0, '0));
    send_op(make_op(ACT_TEST, 12'd64, 1'b0, 6'd0, '0));
    wait_drained();
  endtask

  task automatic test_random_mix(int count, int hot_words);
    repeat (count) send_op(random_op(hot_words));
    wait_drained();
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    repeat (count) send_op(random_op(4));
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    mismatch_count   = 0;
    no_idle          = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_CLEAR;
    in_ch.bit_index  = '0;
    in_ch.bit_value  = 1'b0;
    in_ch.word_index = '0;
    in_ch.word_value = '0;
    for (int i = 0; i < NUM_WORDS; i++) shadow_map[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_bits();
    test_word_ops();
    test_new_bit_report();
    test_undefined_and_clear();
    test_random_mix(150, 8);
    test_back_to_back(80);
    test_random_mix(60, 2);

    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
